>>> src/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; compiled first.
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int PRIO_W = 8;
  localparam int TIME_W = 16;
  localparam int CLK_W  = 24;
  localparam int SUM_W  = 28;
  localparam int NUM_W  = 5;

  localparam logic [CLK_W-1:0] CLK_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [NUM_W-1:0] CNT_MAX = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_LOADED     = 3'd0,
    ST_FULL       = 3'd1,
    ST_ZERO_BURST = 3'd2,
    ST_IDLE       = 3'd3,
    ST_RAN        = 3'd4,
    ST_DONE       = 3'd5
  } status_t;

  typedef struct packed {
    logic              func;
    logic [PRIO_W-1:0] priority_req;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [NUM_W-1:0] process_number;
    logic [CLK_W-1:0] now_time;
    logic [CLK_W-1:0] completion_time;
    logic [CLK_W-1:0] turnaround;
    logic [CLK_W-1:0] waiting;
    logic [SUM_W-1:0] sum_turnaround;
    logic [SUM_W-1:0] sum_waiting;
    logic [NUM_W-1:0] done_count;
  } rsp_t;

  // Best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } cand_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              load;
    logic              run;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [CLK_W-1:0]  clock_now;
  } cell_ctrl_t;

endpackage

>>> src/pps_if.sv
// Valid/ready channel interfaces for command and response words.
// Depends on pps_pkg.
interface pps_cmd_if;
  import pps_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_rsp_if;
  import pps_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pps_cell.sv
// One table entry of the scheduler plus one stage of the winner search chain.
// Depends on pps_pkg.
module pps_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pps_pkg::cell_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]        load_idx,
  input  logic [IDX_W-1:0]        run_idx,
  input  pps_pkg::cand_t          cand_in,
  input  logic [IDX_W-1:0]        idx_in,
  output pps_pkg::cand_t          cand_out,
  output logic [IDX_W-1:0]        idx_out
);
  import pps_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic              vld;
  logic              fin;
  logic [PRIO_W-1:0] prio;
  logic [TIME_W-1:0] arr;
  logic [TIME_W-1:0] bur;
  logic [TIME_W-1:0] rem;

  logic [TIME_W-1:0] rem_next;
  logic              eligible;
  logic              better;

  assign rem_next = rem - {{(TIME_W-1){1'b0}}, (rem != '0)};
  assign eligible = vld && !fin && ({{(CLK_W-TIME_W){1'b0}}, arr} <= ctrl.clock_now);
  // Full ties keep the incoming candidate: it has the lower index.
  assign better   = !cand_in.found || (prio > cand_in.prio) ||
                    ((prio == cand_in.prio) && (arr < cand_in.arrival));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= 1'b0;
      fin            <= 1'b0;
      cand_out.found <= 1'b0;
    end else begin
      if (ctrl.load && load_idx == MY_IDX) begin
        vld <= 1'b1;
        fin <= 1'b0;
      end else if (ctrl.run && run_idx == MY_IDX) begin
        fin <= (rem_next == '0);
      end
      cand_out.found <= cand_in.found || eligible;
    end
    if (ctrl.load && load_idx == MY_IDX) begin
      prio <= ctrl.prio;
      arr  <= ctrl.arrival;
      bur  <= ctrl.burst;
      rem  <= ctrl.burst;
    end else if (ctrl.run && run_idx == MY_IDX) begin
      rem <= rem_next;
    end
    if (eligible && better) begin
      cand_out.prio      <= prio;
      cand_out.arrival   <= arr;
      cand_out.burst     <= bur;
      cand_out.remaining <= rem;
      idx_out            <= MY_IDX;
    end else begin
      cand_out.prio      <= cand_in.prio;
      cand_out.arrival   <= cand_in.arrival;
      cand_out.burst     <= cand_in.burst;
      cand_out.remaining <= cand_in.remaining;
      idx_out            <= idx_in;
    end
  end

endmodule

>>> src/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: controller, statistics and
// the chain of entry cells. Depends on pps_pkg, pps_if.sv and pps_cell.
//
//  channel | dir | words                                  | accepted when
//  --------+-----+----------------------------------------+--------------------
//  cmd     | in  | func, priority_req, arrival, burst     | cmd.valid & ready
//  rsp     | out | status, process_number, times, totals  | rsp.valid & ready
//
// Load words go from accept straight to the response write. Tick words first
// let the candidate walk the cell chain one cell per clock, then take three
// registered arithmetic steps and the response write.
// One word is in flight at a time; cmd.ready is high only while idle.
// The response register holds its word under backpressure; the block finishes
// the next word once the pending one has left.
// Synchronous active-high reset clears the clock, totals, counts and the
// per-cell valid and finished flags; table contents are written by loads.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input logic      clk,
  input logic      rst,
  pps_cmd_if.sink   cmd,
  pps_rsp_if.source rsp
);
  import pps_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] PROC_LIM  = CNT_W'(MAX_PROCS);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_PROCS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CT,
    S_TAT,
    S_WT,
    S_RESP
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  scan_cnt;
  cmd_t              req;

  // Architectural state.
  logic [CNT_W-1:0]  loaded_count;
  logic [CLK_W-1:0]  clock_now;
  logic [SUM_W-1:0]  total_turnaround;
  logic [SUM_W-1:0]  total_waiting;
  logic [NUM_W-1:0]  finished_count;

  // Latched winner and per-tick arithmetic.
  cand_t             win;
  logic [IDX_W-1:0]  win_idx;
  logic [CLK_W-1:0]  ct;
  logic [CLK_W-1:0]  tat;
  logic [CLK_W-1:0]  wt;

  // Cell chain.
  cand_t             cand  [0:MAX_PROCS];
  logic [IDX_W-1:0]  cidx  [0:MAX_PROCS];
  cell_ctrl_t        ctrl;

  logic              out_free;
  logic              win_last;
  logic [IDX_W:0]    win_num;
  logic [CNT_W-1:0]  load_num;
  logic [SUM_W:0]    tat_sum;
  logic [SUM_W:0]    wt_sum;
  logic [SUM_W-1:0]  tat_sat;
  logic [SUM_W-1:0]  wt_sat;
  logic [NUM_W-1:0]  done_next;
  rsp_t              rsp_next;

  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign win_last  = (win.remaining <= {{(TIME_W-1){1'b0}}, 1'b1});
  assign win_num   = {1'b0, win_idx} + {{IDX_W{1'b0}}, 1'b1};
  assign load_num  = loaded_count + {{(CNT_W-1){1'b0}}, 1'b1};
  assign tat_sum   = {1'b0, total_turnaround} + (SUM_W+1)'(tat);
  assign wt_sum    = {1'b0, total_waiting} + (SUM_W+1)'(wt);
  assign tat_sat   = tat_sum[SUM_W] ? SUM_MAX : tat_sum[SUM_W-1:0];
  assign wt_sat    = wt_sum[SUM_W] ? SUM_MAX : wt_sum[SUM_W-1:0];
  assign done_next = (finished_count == CNT_MAX) ? finished_count
                                                 : finished_count + {{(NUM_W-1){1'b0}}, 1'b1};

  // Cell broadcast: loads and runs are applied on the response write.
  always_comb begin
    ctrl.load      = (state == S_RESP) && out_free && (req.func == FUNC_LOAD) &&
                     (loaded_count < PROC_LIM) && (req.burst != '0);
    ctrl.run       = (state == S_RESP) && out_free && (req.func == FUNC_TICK) &&
                     win.found;
    ctrl.prio      = req.priority_req;
    ctrl.arrival   = req.arrival;
    ctrl.burst     = req.burst;
    ctrl.clock_now = clock_now;
  end

  // Response word for the current command; per-entry times stay 0 unless the
  // run entry completes.
  always_comb begin
    rsp_next                = '0;
    rsp_next.status         = ST_LOADED;
    rsp_next.now_time       = clock_now;
    rsp_next.sum_turnaround = total_turnaround;
    rsp_next.sum_waiting    = total_waiting;
    rsp_next.done_count     = finished_count;
    if (req.func == FUNC_LOAD) begin
      if (loaded_count >= PROC_LIM) begin
        rsp_next.status = ST_FULL;
      end else if (req.burst == '0) begin
        rsp_next.status = ST_ZERO_BURST;
      end else begin
        rsp_next.process_number = NUM_W'(load_num);
      end
    end else begin
      rsp_next.now_time = ct;
      if (!win.found) begin
        rsp_next.status = ST_IDLE;
      end else begin
        rsp_next.process_number = NUM_W'(win_num);
        if (win_last) begin
          rsp_next.status          = ST_DONE;
          rsp_next.completion_time = ct;
          rsp_next.turnaround      = tat;
          rsp_next.waiting         = wt;
          rsp_next.sum_turnaround  = tat_sat;
          rsp_next.sum_waiting     = wt_sat;
          rsp_next.done_count      = done_next;
        end else begin
          rsp_next.status = ST_RAN;
        end
      end
    end
  end

  assign cand[0] = '0;
  assign cidx[0] = '0;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    pps_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .load_idx (loaded_count[IDX_W-1:0]),
      .run_idx  (win_idx),
      .cand_in  (cand[i]),
      .idx_in   (cidx[i]),
      .cand_out (cand[i+1]),
      .idx_out  (cidx[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      scan_cnt         <= '0;
      loaded_count     <= '0;
      clock_now        <= '0;
      total_turnaround <= '0;
      total_waiting    <= '0;
      finished_count   <= '0;
      rsp.valid        <= 1'b0;
    end else begin
      // In S_RESP the response write below owns rsp.valid.
      if (rsp.valid && rsp.ready && state != S_RESP) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            req      <= cmd.data;
            scan_cnt <= '0;
            state    <= (cmd.data.func == FUNC_TICK) ? S_SCAN : S_RESP;
          end
        end
        S_SCAN: begin
          // Table is static while scanning; once the scan counter reaches its last value
          // the chain tail holds the winner, which S_CT latches.
          scan_cnt <= scan_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
          if (scan_cnt == SCAN_LAST) state <= S_CT;
        end
        S_CT: begin
          win     <= cand[MAX_PROCS];
          win_idx <= cidx[MAX_PROCS];
          ct      <= (clock_now == CLK_MAX) ? CLK_MAX
                                            : clock_now + {{(CLK_W-1){1'b0}}, 1'b1};
          state   <= S_TAT;
        end
        S_TAT: begin
          tat   <= ct - {{(CLK_W-TIME_W){1'b0}}, win.arrival};
          state <= S_WT;
        end
        S_WT: begin
          wt    <= (tat > {{(CLK_W-TIME_W){1'b0}}, win.burst})
                   ? tat - {{(CLK_W-TIME_W){1'b0}}, win.burst} : '0;
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            rsp.data  <= rsp_next;
            if (req.func == FUNC_LOAD) begin
              if ((loaded_count < PROC_LIM) && (req.burst != '0))
                loaded_count <= load_num;
            end else begin
              clock_now <= ct;
              if (win.found && win_last) begin
                // Entry completes: fold its times into the totals.
                total_turnaround <= tat_sat;
                total_waiting    <= wt_sat;
                finished_count   <= done_next;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for preemptive_priority_scheduler.
// Needs pps_pkg, pps_if.sv and the scheduler RTL; drives command words and
// checks every response word against a cycle-free model of the scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int N_ENTRIES      = MAX_PROCS_DEF;
  localparam int RANDOM_WORDS   = 1400;
  // Nothing legal keeps the channels quiet anywhere near this long, not even a
  // tick word or the long receiver hold-off.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * (N_ENTRIES + 5);
  // Receiver backpressure burst, and a window with no random idling at all.
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_FROM     = 600;
  localparam int QUIET_TO       = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pps_cmd_if cmd_ch ();
  pps_rsp_if rsp_ch ();

  preemptive_priority_scheduler #(.MAX_PROCS(N_ENTRIES)) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scheduler model: process table, clock and running totals
  // ---------------------------------------------------------------------
  logic [PRIO_W-1:0] tbl_prio    [N_ENTRIES];
  logic [TIME_W-1:0] tbl_arrival [N_ENTRIES];
  logic [TIME_W-1:0] tbl_burst   [N_ENTRIES];
  logic [TIME_W-1:0] tbl_left    [N_ENTRIES];
  logic              tbl_done    [N_ENTRIES];
  int                tbl_loaded   = 0;
  logic [CLK_W-1:0]  sched_clock  = '0;
  logic [SUM_W-1:0]  total_tat    = '0;
  logic [SUM_W-1:0]  total_wait   = '0;
  logic [NUM_W-1:0]  finished_cnt = '0;

  cmd_t sched_cmds[$];          // command words not yet offered
  rsp_t predicted_reports[$];   // responses owed by the scheduler
  int   ticks_planned = 0;      // clock value the generator expects next
  int   words_checked = 0;
  int   fail_count    = 0;
  int   idle_cycles   = 0;
  logic cmd_taken     = 1'b0;
  int   hold_left     = 0;
  logic hold_done     = 1'b0;
  logic quiet_window;

  assign quiet_window = (words_checked >= QUIET_FROM) && (words_checked < QUIET_TO);

  // Applies one command word to the model and returns the response it owes.
  function automatic rsp_t schedule_step(cmd_t c);
    rsp_t             r;
    logic             found;
    int               best;
    int               i;
    logic [CLK_W-1:0] tat;
    logic [CLK_W-1:0] wt;
    logic [SUM_W:0]   acc;
    r = '0;
    if (c.func == FUNC_LOAD) begin
      // Full-table check wins over the zero-burst check.
      if (tbl_loaded >= N_ENTRIES) begin
        r.status = ST_FULL;
      end else if (c.burst == '0) begin
        r.status = ST_ZERO_BURST;
      end else begin
        tbl_prio[tbl_loaded]    = c.priority_req;
        tbl_arrival[tbl_loaded] = c.arrival;
        tbl_burst[tbl_loaded]   = c.burst;
        tbl_left[tbl_loaded]    = c.burst;
        tbl_done[tbl_loaded]    = 1'b0;
        tbl_loaded++;
        r.status         = ST_LOADED;
        r.process_number = NUM_W'(tbl_loaded);
      end
    end else begin
      // Highest priority among arrived, unfinished entries; ties go to the
      // earlier arrival, then to the lower index (strict compares below).
      found = 1'b0;
      best  = 0;
      for (i = 0; i < tbl_loaded; i++) begin
        if (!tbl_done[i] && CLK_W'(tbl_arrival[i]) <= sched_clock) begin
          if (!found || tbl_prio[i] > tbl_prio[best] ||
              (tbl_prio[i] == tbl_prio[best] && tbl_arrival[i] < tbl_arrival[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (sched_clock != CLK_MAX) sched_clock++;
      if (!found) begin
        r.status = ST_IDLE;
      end else begin
        r.process_number = NUM_W'(best + 1);
        if (tbl_left[best] != '0) tbl_left[best]--;
        if (tbl_left[best] == '0) begin
          tat = sched_clock - CLK_W'(tbl_arrival[best]);
          wt  = (tat > CLK_W'(tbl_burst[best])) ? tat - CLK_W'(tbl_burst[best]) : '0;
          acc = total_tat + tat;
          total_tat = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
          acc = total_wait + wt;
          total_wait = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
          if (finished_cnt != CNT_MAX) finished_cnt++;
          tbl_done[best]    = 1'b1;
          r.status          = ST_DONE;
          r.completion_time = sched_clock;
          r.turnaround      = tat;
          r.waiting         = wt;
        end else begin
          r.status = ST_RAN;
        end
      end
    end
    r.now_time       = sched_clock;
    r.sum_turnaround = total_tat;
    r.sum_waiting    = total_wait;
    r.done_count     = finished_cnt;
    return r;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void add_load(int prio, int arr, int burst);
    cmd_t c;
    c.func         = FUNC_LOAD;
    c.priority_req = PRIO_W'(prio);
    c.arrival      = TIME_W'(arr);
    c.burst        = TIME_W'(burst);
    sched_cmds.push_back(c);
  endfunction

  function automatic void add_tick();
    cmd_t c;
    // Load fields are don't-care on a tick; fill them with noise.
    c.func         = FUNC_TICK;
    c.priority_req = PRIO_W'($urandom);
    c.arrival      = TIME_W'($urandom);
    c.burst        = TIME_W'($urandom);
    sched_cmds.push_back(c);
    ticks_planned++;
  endfunction

  // ---------------------------------------------------------------------
  // Command driver: next word goes out at the falling edge once the
  // previous one was taken; valid never drops while a word waits.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (sched_cmds.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 15)) begin
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= sched_cmds.pop_front();
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls, plus one long hold-off that lets the
  // response register fill so the scheduler has to drop cmd ready.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && words_checked >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= quiet_window || ($urandom_range(0, 99) >= 15);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on each accepted command word, check each accepted
  // response word against the oldest prediction; watchdog on no progress.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    cmd_taken <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && cmd_ch.valid && cmd_ch.ready)
      predicted_reports.push_back(schedule_step(cmd_ch.data));
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_reports.size() == 0) begin
        $error("response word with no command outstanding");
        fail_count++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", want.status, rsp_ch.data.status);
        check_field("process_number", want.process_number, rsp_ch.data.process_number);
        check_field("now_time", want.now_time, rsp_ch.data.now_time);
        check_field("completion_time", want.completion_time, rsp_ch.data.completion_time);
        check_field("turnaround", want.turnaround, rsp_ch.data.turnaround);
        check_field("waiting", want.waiting, rsp_ch.data.waiting);
        check_field("sum_turnaround", want.sum_turnaround, rsp_ch.data.sum_turnaround);
        check_field("sum_waiting", want.sum_waiting, rsp_ch.data.sum_waiting);
        check_field("done_count", want.done_count, rsp_ch.data.done_count);
      end
      words_checked++;
    end
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("preemptive_priority_scheduler test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int sel;
    int p;
    int a;
    int b;

    // Directed: idle tick on an empty table, zero burst, an entry that never
    // arrives, ties on priority (earlier arrival wins, then lower index),
    // a load after ticks that preempts, and an idle tick once all finished.
    add_tick();
    add_load(7, 0, 0);
    add_load(255, 65535, 65535);
    add_load(0, 0, 2);
    add_load(4, 1, 3);
    add_load(4, 1, 1);
    add_load(4, 0, 2);
    add_tick();
    add_tick();
    add_load(200, 3, 2);
    repeat (9) add_tick();

    // Random: mostly ticks; loads keep arrivals near the clock the run will
    // reach so entries keep competing. Once the table is full, loads (and
    // zero-burst loads) check that the full test takes precedence.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        sel = $urandom_range(0, 99);
        p = (sel < 60) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (sel < 50)      a = ticks_planned + $urandom_range(0, 40);
        else if (sel < 80) a = $urandom_range(0, ticks_planned + 100);
        else               a = $urandom_range(0, 65535);
        sel = $urandom_range(0, 99);
        if (sel < 60)      b = $urandom_range(1, 40);
        else if (sel < 80) b = $urandom_range(1, 300);
        else if (sel < 90) b = 0;
        else               b = $urandom_range(0, 65535);
        add_load(p, a, b);
      end else begin
        add_tick();
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (sched_cmds.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (predicted_reports.size() != 0) @(posedge clk);
    // Catch any stray word after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("preemptive_priority_scheduler test passed");
    else
      $display("preemptive_priority_scheduler test failed");
    $finish;
  end

endmodule

>>> files.f
src/pps_pkg.sv
src/pps_if.sv
src/pps_cell.sv
src/preemptive_priority_scheduler.sv
tb/tb.sv
